// ----- rtl/fdt_pkg.sv -----
// Package for the file descriptor offset table: sizes, request and response
// payload types, operation codes. No dependencies.
`default_nettype none

package fdt_pkg;

    localparam int SLOT_COUNT  = 256;
    localparam int OFFSET_BITS = 48;

    localparam int SLOT_BITS = $clog2(SLOT_COUNT);
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int OFF_W     = OFFSET_BITS;
    localparam int FD_W      = 8;
    localparam int FD_CMP_W  = (CNT_W > FD_W) ? CNT_W : FD_W;
    localparam int POS_W     = 48;
    localparam int SIZE_W    = 48;
    localparam int DONE_W    = 32;
    localparam int DELTA_W   = 48;

    typedef enum logic [1:0] {
        OP_OPEN  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_SEEK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        WH_SET  = 2'd0,
        WH_CUR  = 2'd1,
        WH_END  = 2'd2,
        WH_NONE = 2'd3
    } t_whence;

    typedef struct packed {
        t_op                        opcode;
        logic [FD_W-1:0]            fd;
        logic                       file_present;
        logic                       append_flag;
        logic [SIZE_W-1:0]          file_size;
        logic signed [DONE_W-1:0]   bytes_done;
        logic signed [DELTA_W-1:0]  seek_delta;
        t_whence                    whence;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [FD_W-1:0]    new_fd;
        logic [POS_W-1:0]   position;
    } t_rsp;

    typedef struct packed {
        logic               append;
        logic [OFF_W-1:0]   cursor;
    } t_slot;

endpackage

`default_nettype wire

// ----- rtl/fdt_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on fdt_pkg.
`default_nettype none

interface fdt_req_if;
    logic          valid;
    logic          ready;
    fdt_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fdt_rsp_if;
    logic          valid;
    logic          ready;
    fdt_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/file_descriptor_offset_table_unit.sv -----
// File descriptor offset table: slot memory, fill count and a two-state
// sequencer around one shared offset adder. Depends on fdt_pkg and fdt_if.
//
//   channel  | dir | handshake     | payload
//   i_req    | in  | valid / ready | opcode, fd, file_present, append_flag,
//            |     |               | file_size, bytes_done, seek_delta, whence
//   o_rsp    | out | valid / ready | status, new_fd, position
//
// On a request the accept edge reads the slot memory; the execute state then
// runs the adder and writes slot and response register together.
// The execute cycle waits while the response register is still full.
// Slots fill in order and never close, so a fill count stands for the valid
// bits; reset clears it at once and no clearing pass is needed.
`default_nettype none

module file_descriptor_offset_table_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    fdt_req_if.sink     i_req,
    fdt_rsp_if.source   o_rsp
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                         r_state, n_state;
    logic [fdt_pkg::CNT_W-1:0]      r_count, n_count;
    fdt_pkg::t_req                  r_req;
    fdt_pkg::t_slot                 r_slot;
    logic                           r_rsp_valid, n_rsp_valid;
    fdt_pkg::t_rsp                  r_rsp, n_rsp;

    fdt_pkg::t_slot                 r_mem [fdt_pkg::SLOT_COUNT];

    logic                           req_accept;
    logic [fdt_pkg::FD_CMP_W-1:0]   in_fd_ext;
    logic [fdt_pkg::FD_CMP_W-1:0]   fd_ext;
    logic                           fd_ok;
    logic                           open_ok;
    logic                           op_ok;
    logic                           is_open;
    logic                           done_pos;
    logic [fdt_pkg::OFF_W-1:0]      size_o;
    logic [fdt_pkg::OFF_W-1:0]      delta_o;
    logic [fdt_pkg::OFF_W-1:0]      done_o;
    logic [fdt_pkg::OFF_W-1:0]      add_a, add_b, sum;
    logic [fdt_pkg::OFF_W-1:0]      pos;
    logic                           can_out;
    logic                           finish;
    logic                           wr_en;
    logic [fdt_pkg::SLOT_BITS-1:0]  wr_idx;
    fdt_pkg::t_slot                 wr_word;

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    assign in_fd_ext   = fdt_pkg::FD_CMP_W'(i_req.data.fd);

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // slot memory: read on accept, write at the end of execute
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_req  <= i_req.data;
            r_slot <= r_mem[in_fd_ext[fdt_pkg::SLOT_BITS-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_idx] <= wr_word;
        end
    end

    always_comb begin
        is_open  = (r_req.opcode == fdt_pkg::OP_OPEN);
        fd_ext   = fdt_pkg::FD_CMP_W'(r_req.fd);
        fd_ok    = fd_ext < fdt_pkg::FD_CMP_W'(r_count);
        open_ok  = r_req.file_present && (r_count < fdt_pkg::CNT_W'(fdt_pkg::SLOT_COUNT));
        op_ok    = is_open ? open_ok : fd_ok;
        done_pos = !r_req.bytes_done[fdt_pkg::DONE_W-1] && (r_req.bytes_done != '0);
        size_o   = fdt_pkg::OFF_W'(r_req.file_size);
        delta_o  = fdt_pkg::OFF_W'(r_req.seek_delta);
        done_o   = fdt_pkg::OFF_W'(r_req.bytes_done);

        add_a = r_slot.cursor;
        add_b = '0;
        case (r_req.opcode)
            fdt_pkg::OP_OPEN: begin
                add_a = r_req.append_flag ? size_o : '0;
            end
            fdt_pkg::OP_READ: begin
                add_b = done_pos ? done_o : '0;
            end
            fdt_pkg::OP_WRITE: begin
                if (r_slot.append) begin
                    add_a = size_o;
                end
                add_b = done_pos ? done_o : '0;
            end
            fdt_pkg::OP_SEEK: begin
                case (r_req.whence)
                    fdt_pkg::WH_SET: begin
                        add_a = '0;
                        add_b = delta_o;
                    end
                    fdt_pkg::WH_CUR: add_b = delta_o;
                    fdt_pkg::WH_END: begin
                        add_a = size_o;
                        add_b = delta_o;
                    end
                    default: add_b = '0;
                endcase
            end
            default: add_b = '0;
        endcase

        sum = add_a + add_b;
        pos = (r_req.opcode == fdt_pkg::OP_SEEK) ? sum : add_a;

        wr_idx         = is_open ? r_count[fdt_pkg::SLOT_BITS-1:0]
                                 : fd_ext[fdt_pkg::SLOT_BITS-1:0];
        wr_word.append = is_open ? r_req.append_flag : r_slot.append;
        wr_word.cursor = sum;

        can_out = !r_rsp_valid || o_rsp.ready;
        finish  = (r_state == ST_EXEC) && can_out;
        wr_en   = finish && op_ok;

        n_state     = r_state;
        n_count     = r_count;
        n_rsp_valid = r_rsp_valid && !o_rsp.ready;
        n_rsp       = r_rsp;
        case (r_state)
            ST_IDLE: begin
                if (req_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (finish) begin
                    n_state         = ST_IDLE;
                    n_rsp_valid     = 1'b1;
                    n_rsp.status    = !op_ok;
                    n_rsp.new_fd    = (is_open && open_ok) ? fdt_pkg::FD_W'(r_count) : '0;
                    n_rsp.position  = (!is_open && fd_ok) ? fdt_pkg::POS_W'(pos) : '0;
                    if (is_open && open_ok) begin
                        n_count = r_count + fdt_pkg::CNT_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
        r_rsp <= n_rsp;
    end

endmodule

`default_nettype wire

// ----- rtl/fdt_checker.sv -----
// Port-level checks for the file descriptor offset table, bound to the top
// level. Depends on fdt_pkg.
`default_nettype none

module fdt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          i_req_ready,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire fdt_pkg::t_rsp i_rsp_data
);

    logic req_accept;
    assign req_accept = i_req_valid && i_req_ready;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_data))
        else $error("response changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> !i_req_ready)
        else $error("request taken while one is in execution");

    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(req_accept, 2))
        else $error("response without a request two cycles earlier");

endmodule

bind file_descriptor_offset_table_unit fdt_checker u_fdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire
